// ----- sv/wavhp_pkg.sv -----
// shared types, constants and helpers for the wav header parser
`timescale 1ns / 1ps

package wavhp_pkg;

    localparam int HDR_LEN = 44;
    localparam int IDX_W   = $clog2(HDR_LEN);
    localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HDR_LEN - 1);

    // byte offsets in the canonical header
    localparam logic [IDX_W-1:0] OFS_RIFF     = IDX_W'(0);
    localparam logic [IDX_W-1:0] OFS_WAVE     = IDX_W'(8);
    localparam logic [IDX_W-1:0] OFS_FMT      = IDX_W'(12);
    localparam logic [IDX_W-1:0] OFS_FMT_LEN  = IDX_W'(16);
    localparam logic [IDX_W-1:0] OFS_FMT_CODE = IDX_W'(20);
    localparam logic [IDX_W-1:0] OFS_CHANNELS = IDX_W'(22);
    localparam logic [IDX_W-1:0] OFS_RATE     = IDX_W'(24);
    localparam logic [IDX_W-1:0] OFS_ALIGN    = IDX_W'(32);
    localparam logic [IDX_W-1:0] OFS_DEPTH    = IDX_W'(34);
    localparam logic [IDX_W-1:0] OFS_DATA     = IDX_W'(36);

    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_FMT  = "fmt ";
    localparam logic [31:0] TAG_DATA = "data";
    localparam logic [7:0]  CHR_F    = "F";
    localparam logic [7:0]  CHR_X    = "X";

    localparam logic [31:0] FMT_CHUNK_LEN = 32'h0000_0010;
    localparam logic [15:0] FMT_CODE_PCM  = 16'h0001;

    // divider width
    localparam int DIV_W = 16;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // error codes
    localparam logic [3:0] ERR_NONE  = 4'd0;
    localparam logic [3:0] ERR_RIFF  = 4'd1;
    localparam logic [3:0] ERR_WAVE  = 4'd2;
    localparam logic [3:0] ERR_FMT   = 4'd3;
    localparam logic [3:0] ERR_PCM   = 4'd4;
    localparam logic [3:0] ERR_CONT  = 4'd5;
    localparam logic [3:0] ERR_DEPTH = 4'd6;
    localparam logic [3:0] ERR_DATA  = 4'd7;
    localparam logic [3:0] ERR_CHAN  = 4'd8;

    // sample formats, big endian variant is the little endian code plus one
    localparam logic [3:0] FMT_U8      = 4'd0;
    localparam logic [3:0] FMT_S16LE   = 4'd1;
    localparam logic [3:0] FMT_S24_3LE = 4'd3;
    localparam logic [3:0] FMT_S24LE   = 4'd5;
    localparam logic [3:0] FMT_S32LE   = 4'd7;

    localparam logic [15:0] DEPTH_8  = 16'd8;
    localparam logic [15:0] DEPTH_16 = 16'd16;
    localparam logic [15:0] DEPTH_24 = 16'd24;
    localparam logic [15:0] DEPTH_32 = 16'd32;
    localparam logic [15:0] CONT_3   = 16'd3;
    localparam logic [15:0] CONT_4   = 16'd4;

    typedef struct packed {
        logic        riff_ok;
        logic        wave_ok;
        logic        fmt_ok;
        logic        data_ok;
        logic        big_endian;
        logic [31:0] fmt_len;
        logic [15:0] fmt_code;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] align;
        logic [15:0] depth;
    } t_hdr_info;

    // picks byte j of a four character tag, first character at j = 0
    function automatic logic [7:0] tag_pick(input logic [31:0] tag, input logic [1:0] j);
        logic [7:0] b;
        begin
            unique case (j)
                2'd0: b = tag[31:24];
                2'd1: b = tag[23:16];
                2'd2: b = tag[15:8];
                2'd3: b = tag[7:0];
            endcase
            return b;
        end
    endfunction

    // expected byte at a tag position of the header, zero elsewhere
    function automatic logic [7:0] tag_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        begin
            b = 8'h00;
            if (idx[IDX_W-1:2] == OFS_RIFF[IDX_W-1:2]) begin
                b = tag_pick(TAG_RIFF, idx[1:0]);
            end else if (idx[IDX_W-1:2] == OFS_WAVE[IDX_W-1:2]) begin
                b = tag_pick(TAG_WAVE, idx[1:0]);
            end else if (idx[IDX_W-1:2] == OFS_FMT[IDX_W-1:2]) begin
                b = tag_pick(TAG_FMT, idx[1:0]);
            end else if (idx[IDX_W-1:2] == OFS_DATA[IDX_W-1:2]) begin
                b = tag_pick(TAG_DATA, idx[1:0]);
            end
            return b;
        end
    endfunction

endpackage

// ----- sv/wavhp_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module wavhp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [wavhp_pkg::DIV_W-1:0]  i_dividend,
    input  logic [wavhp_pkg::DIV_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [wavhp_pkg::DIV_W-1:0]  o_quot,
    output logic [wavhp_pkg::DIV_W-1:0]  o_rem
);

    logic [wavhp_pkg::CNT_W-1:0] r_cnt;
    logic                        r_done;
    logic [wavhp_pkg::DIV_W-1:0] r_quo;
    logic [wavhp_pkg::DIV_W-1:0] r_rem;
    logic [wavhp_pkg::DIV_W-1:0] r_dvs;
    logic [wavhp_pkg::DIV_W:0]   shifted;
    logic [wavhp_pkg::DIV_W+1:0] diff;

    assign shifted = {r_rem, r_quo[wavhp_pkg::DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == wavhp_pkg::CNT_W'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= wavhp_pkg::CNT_W'(wavhp_pkg::DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - wavhp_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            // no borrow: the divisor fits, take the difference
            if (!diff[wavhp_pkg::DIV_W+1]) begin
                r_rem <= diff[wavhp_pkg::DIV_W-1:0];
                r_quo <= {r_quo[wavhp_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[wavhp_pkg::DIV_W-1:0];
                r_quo <= {r_quo[wavhp_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- sv/wavhp_hdr.sv -----
// header byte capture: tag checks and field assembly as bytes arrive
`timescale 1ns / 1ps

module wavhp_hdr (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [wavhp_pkg::IDX_W-1:0]  i_idx,
    input  logic [7:0]                   i_byte,
    output wavhp_pkg::t_hdr_info         o_info
);

    wavhp_pkg::t_hdr_info r_info;
    logic                 hit;
    logic [15:0]          n_sh16;
    logic [31:0]          n_sh32;
    logic [15:0]          sel16;
    logic [31:0]          sel32;

    assign hit = (i_byte == wavhp_pkg::tag_byte(i_idx));

    // pick the field the current byte belongs to
    always_comb begin
        sel16 = r_info.fmt_code;
        sel32 = r_info.fmt_len;
        if (i_idx == wavhp_pkg::OFS_CHANNELS || i_idx == wavhp_pkg::OFS_CHANNELS + 1) begin
            sel16 = r_info.channels;
        end else if (i_idx == wavhp_pkg::OFS_ALIGN || i_idx == wavhp_pkg::OFS_ALIGN + 1) begin
            sel16 = r_info.align;
        end else if (i_idx == wavhp_pkg::OFS_DEPTH || i_idx == wavhp_pkg::OFS_DEPTH + 1) begin
            sel16 = r_info.depth;
        end
        if (i_idx[wavhp_pkg::IDX_W-1:2] == wavhp_pkg::OFS_RATE[wavhp_pkg::IDX_W-1:2]) begin
            sel32 = r_info.rate;
        end
    end

    // big endian shifts in at the bottom, little endian at the top
    assign n_sh16 = r_info.big_endian ? {sel16[7:0], i_byte} : {i_byte, sel16[15:8]};
    assign n_sh32 = r_info.big_endian ? {sel32[23:0], i_byte} : {i_byte, sel32[31:8]};

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            case (i_idx)
                wavhp_pkg::OFS_RIFF: r_info.riff_ok <= hit;
                wavhp_pkg::OFS_RIFF + 1, wavhp_pkg::OFS_RIFF + 2: begin
                    r_info.riff_ok <= r_info.riff_ok & hit;
                end
                wavhp_pkg::OFS_RIFF + 3: begin
                    r_info.riff_ok    <= r_info.riff_ok &
                        (i_byte == wavhp_pkg::CHR_F || i_byte == wavhp_pkg::CHR_X);
                    r_info.big_endian <= (i_byte == wavhp_pkg::CHR_X);
                end
                wavhp_pkg::OFS_WAVE: r_info.wave_ok <= hit;
                wavhp_pkg::OFS_WAVE + 1, wavhp_pkg::OFS_WAVE + 2, wavhp_pkg::OFS_WAVE + 3: begin
                    r_info.wave_ok <= r_info.wave_ok & hit;
                end
                wavhp_pkg::OFS_FMT: r_info.fmt_ok <= hit;
                wavhp_pkg::OFS_FMT + 1, wavhp_pkg::OFS_FMT + 2, wavhp_pkg::OFS_FMT + 3: begin
                    r_info.fmt_ok <= r_info.fmt_ok & hit;
                end
                wavhp_pkg::OFS_DATA: r_info.data_ok <= hit;
                wavhp_pkg::OFS_DATA + 1, wavhp_pkg::OFS_DATA + 2, wavhp_pkg::OFS_DATA + 3: begin
                    r_info.data_ok <= r_info.data_ok & hit;
                end
                wavhp_pkg::OFS_FMT_LEN, wavhp_pkg::OFS_FMT_LEN + 1,
                wavhp_pkg::OFS_FMT_LEN + 2, wavhp_pkg::OFS_FMT_LEN + 3: begin
                    r_info.fmt_len <= n_sh32;
                end
                wavhp_pkg::OFS_RATE, wavhp_pkg::OFS_RATE + 1,
                wavhp_pkg::OFS_RATE + 2, wavhp_pkg::OFS_RATE + 3: begin
                    r_info.rate <= n_sh32;
                end
                wavhp_pkg::OFS_FMT_CODE, wavhp_pkg::OFS_FMT_CODE + 1: r_info.fmt_code <= n_sh16;
                wavhp_pkg::OFS_CHANNELS, wavhp_pkg::OFS_CHANNELS + 1: r_info.channels <= n_sh16;
                wavhp_pkg::OFS_ALIGN, wavhp_pkg::OFS_ALIGN + 1: r_info.align <= n_sh16;
                wavhp_pkg::OFS_DEPTH, wavhp_pkg::OFS_DEPTH + 1: r_info.depth <= n_sh16;
                default: ;
            endcase
        end
    end

    assign o_info = r_info;

endmodule

// ----- sv/wav_header_parse_channel_extract.sv -----
// top level: byte sequencer, header evaluation and output register
`timescale 1ns / 1ps

// WAV header parser with channel extraction.
// Input channel: one file byte per transfer (i_data_byte), i_first_byte marks
// the first byte of a file and restarts header collection at byte 0.
// Output channel: one result per transfer; o_kind tells a data byte from a
// header accepted or header rejected report. Unused fields read as zero.
// Config: i_cfg_we writes i_cfg_data into the mono mode bit; write it only
// while the block is idle.
// The 44 header bytes are taken at one byte per cycle while the input is not
// stalled. After the last one the 16-step divider works out bytes per channel
// (block align over channel count): the input is stalled while it runs and the
// report appears in the output register in the cycle after that.
// Data bytes then pass through the output register, one byte per cycle while
// the receiver does not stall; a byte that is dropped gives no result. After a
// rejected header all bytes are dropped until the next first byte.
// When the receiver stalls a held result, the input stalls too, so nothing
// is lost. Reset puts the block in header collection with mono mode off.

module wav_header_parse_channel_extract (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [3:0]  o_error_code,
    output logic [3:0]  o_sample_format,
    output logic [15:0] o_channel_total,
    output logic [15:0] o_out_channels,
    output logic [31:0] o_sample_rate,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data
);

    typedef enum logic [3:0] {
        ST_HDR  = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_PASS = 4'b0100,
        ST_DROP = 4'b1000
    } t_state;

    t_state                       r_state;
    logic [wavhp_pkg::IDX_W-1:0]  r_hcnt;
    logic                         r_mono;
    logic                         r_out_valid;
    logic [15:0]                  r_chan;
    logic [15:0]                  r_cbytes;
    logic [15:0]                  r_fbytes;
    logic [15:0]                  r_fpos;
    logic [15:0]                  n_fpos;

    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic [3:0]  r_err;
    logic [3:0]  r_fmt;
    logic [15:0] r_ch_tot;
    logic [15:0] r_ch_out;
    logic [31:0] r_rate;

    wavhp_pkg::t_hdr_info         info;
    logic [wavhp_pkg::IDX_W-1:0]  idx;
    logic                         in_acc;
    logic                         out_take;
    logic                         hdr_we;
    logic                         hdr_last;
    logic                         div_done;
    logic [15:0]                  div_quot;
    logic [15:0]                  div_rem;
    logic                         load_rpt;
    logic                         load_data;
    logic                         pass;
    logic [3:0]                   rpt_err;
    logic [3:0]                   rpt_fmt;
    logic [3:0]                   be_ofs;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state == ST_DIV) || (r_out_valid && i_out_stall);

    assign idx      = i_first_byte ? '0 : r_hcnt;
    assign hdr_we   = in_acc && (i_first_byte || r_state == ST_HDR);
    assign hdr_last = hdr_we && (idx == wavhp_pkg::HDR_LAST);

    wavhp_hdr u_hdr (
        .i_clk  (i_clk),
        .i_we   (hdr_we),
        .i_idx  (idx),
        .i_byte (i_data_byte),
        .o_info (info)
    );

    wavhp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (hdr_last),
        .i_dividend (info.align),
        .i_divisor  (info.channels),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // header checks in priority order
    assign be_ofs = {3'b000, info.big_endian};
    always_comb begin
        rpt_err = wavhp_pkg::ERR_NONE;
        rpt_fmt = wavhp_pkg::FMT_U8;
        priority if (!info.riff_ok) begin
            rpt_err = wavhp_pkg::ERR_RIFF;
        end else if (!info.wave_ok) begin
            rpt_err = wavhp_pkg::ERR_WAVE;
        end else if (!info.fmt_ok || info.fmt_len != wavhp_pkg::FMT_CHUNK_LEN) begin
            rpt_err = wavhp_pkg::ERR_FMT;
        end else if (info.fmt_code != wavhp_pkg::FMT_CODE_PCM) begin
            rpt_err = wavhp_pkg::ERR_PCM;
        end else if (info.channels == '0) begin
            rpt_err = wavhp_pkg::ERR_CHAN;
        end else if (info.depth == wavhp_pkg::DEPTH_8) begin
            rpt_fmt = wavhp_pkg::FMT_U8;
        end else if (info.depth == wavhp_pkg::DEPTH_16) begin
            rpt_fmt = wavhp_pkg::FMT_S16LE + be_ofs;
        end else if (info.depth == wavhp_pkg::DEPTH_24) begin
            priority if (div_quot == wavhp_pkg::CONT_3) begin
                rpt_fmt = wavhp_pkg::FMT_S24_3LE + be_ofs;
            end else if (div_quot == wavhp_pkg::CONT_4) begin
                rpt_fmt = wavhp_pkg::FMT_S24LE + be_ofs;
            end else begin
                rpt_err = wavhp_pkg::ERR_CONT;
            end
        end else if (info.depth == wavhp_pkg::DEPTH_32) begin
            rpt_fmt = wavhp_pkg::FMT_S32LE + be_ofs;
        end else begin
            rpt_err = wavhp_pkg::ERR_DEPTH;
        end
        if (rpt_err == wavhp_pkg::ERR_NONE && !info.data_ok) begin
            rpt_err = wavhp_pkg::ERR_DATA;
        end
    end

    assign load_rpt = (r_state == ST_DIV) && div_done;

    // frame walk for data bytes
    always_comb begin
        n_fpos = r_fpos;
        if (r_fbytes != '0) begin
            n_fpos = ({1'b0, r_fpos} + 17'd1 == {1'b0, r_fbytes}) ? '0 : r_fpos + 16'd1;
        end
    end
    assign pass = !(r_mono && r_chan > 16'd1) || (r_fbytes != '0 && r_fpos < r_cbytes);
    assign load_data = in_acc && !i_first_byte && (r_state == ST_PASS) && pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HDR;
            r_hcnt      <= '0;
            r_mono      <= 1'b0;
            r_out_valid <= 1'b0;
            r_chan      <= '0;
            r_cbytes    <= '0;
            r_fbytes    <= '0;
            r_fpos      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mono <= i_cfg_data;
            end
            if (load_rpt || load_data) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (hdr_we) begin
                r_state <= hdr_last ? ST_DIV : ST_HDR;
                r_hcnt  <= hdr_last ? '0 : idx + wavhp_pkg::IDX_W'(1);
            end else if (load_rpt) begin
                if (rpt_err == wavhp_pkg::ERR_NONE) begin
                    r_state  <= ST_PASS;
                    r_chan   <= info.channels;
                    r_cbytes <= div_quot;
                    // quotient times channels is the dividend minus the remainder
                    r_fbytes <= info.align - div_rem;
                    r_fpos   <= '0;
                end else begin
                    r_state <= ST_DROP;
                end
            end else if (in_acc && r_state == ST_PASS) begin
                r_fpos <= n_fpos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_rpt) begin
            r_byte <= '0;
            if (rpt_err == wavhp_pkg::ERR_NONE) begin
                r_kind   <= wavhp_pkg::KIND_ACCEPT;
                r_err    <= wavhp_pkg::ERR_NONE;
                r_fmt    <= rpt_fmt;
                r_ch_tot <= info.channels;
                r_ch_out <= r_mono ? 16'd1 : info.channels;
                r_rate   <= info.rate;
            end else begin
                r_kind   <= wavhp_pkg::KIND_REJECT;
                r_err    <= rpt_err;
                r_fmt    <= '0;
                r_ch_tot <= '0;
                r_ch_out <= '0;
                r_rate   <= '0;
            end
        end else if (load_data) begin
            r_kind   <= wavhp_pkg::KIND_DATA;
            r_byte   <= i_data_byte;
            r_err    <= wavhp_pkg::ERR_NONE;
            r_fmt    <= '0;
            r_ch_tot <= '0;
            r_ch_out <= '0;
            r_rate   <= '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_out_byte      = r_byte;
    assign o_error_code    = r_err;
    assign o_sample_format = r_fmt;
    assign o_channel_total = r_ch_tot;
    assign o_out_channels  = r_ch_out;
    assign o_sample_rate   = r_rate;

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("divider finished outside the divide state");

    a_out_empty_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> !r_out_valid)
        else $error("output register busy while the header report is pending");

    a_fpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS && r_fbytes != '0) |-> r_fpos < r_fbytes)
        else $error("frame position ran past the frame size");
`endif

endmodule
